// ===== rtl/core/dcp_pkg.sv =====
`default_nettype none
package dcp_pkg;

	// field widths
	localparam int COORD_W  = 32;
	localparam int IDX_W    = 12;
	localparam int REST_W   = 31;
	localparam int WEIGHT_W = 17;
	localparam int WEIGHT_FRAC = 16;
	localparam int ENTRY_W  = 3 * COORD_W;

	// shared multiplier operand width, covers a 33-bit signed offset
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;

	// square root of the squared length fits in this many bits
	localparam int ROOT_W = 34;
	localparam int SQ_W   = 66;

	// parameter defaults
	localparam int PARTICLES_DEF     = 4096;
	localparam int FRACTION_BITS_DEF = 16;

	// opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/distance_constraint_projection.sv =====
`default_nettype none
// Distance-constraint projection over a store of PARTICLES positions (three signed
// fixed-point coordinates with FRACTION_BITS fraction bits). Opcode 0 writes a
// position, 2 reads one back, 1 solves one constraint between index_a and index_b
// in place. Every item gives exactly one result transfer. One item is worked at a
// time under a sequencer around one shared multiplier and a bit-serial root and
// divide step: a solve goes through two store reads, three squares, 34 square-root
// steps, 34 + FRACTION_BITS divide steps, two weight products, six correction
// products and two store writes. A zero-length solve stops after the squares and
// reports degenerate. The input also stalls while a finished result waits for the
// output register. Entries never written read as unknown data.
module distance_constraint_projection import dcp_pkg::*; #(
	parameter int PARTICLES     = PARTICLES_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              opcode,
	input  wire logic [IDX_W-1:0]        index_a,
	input  wire logic [IDX_W-1:0]        index_b,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [COORD_W-1:0] pos_z,
	input  wire logic [REST_W-1:0]       rest_length,
	input  wire logic [WEIGHT_W-1:0]     weight_a,
	input  wire logic [WEIGHT_W-1:0]     weight_b,
	input  wire logic                    end_of_range,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [COORD_W-1:0]    read_x,
	output logic signed [COORD_W-1:0]    read_y,
	output logic signed [COORD_W-1:0]    read_z,
	output logic                         degenerate,
	output logic                         range_done
);

	localparam int AW    = $clog2(PARTICLES);
	localparam int NUMW  = ROOT_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(NUMW);
	localparam logic [PROD_W-1:0] RND_F = (PROD_W'(1) << FRACTION_BITS) - PROD_W'(1);
	localparam logic [PROD_W-1:0] RND_W = (PROD_W'(1) << WEIGHT_FRAC) - PROD_W'(1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_DIFF = 4'd3;
	localparam logic [3:0] S_SQM  = 4'd4;
	localparam logic [3:0] S_SQA  = 4'd5;
	localparam logic [3:0] S_ZCHK = 4'd6;
	localparam logic [3:0] S_SQRT = 4'd7;
	localparam logic [3:0] S_DVI  = 4'd8;
	localparam logic [3:0] S_DIV  = 4'd9;
	localparam logic [3:0] S_DVE  = 4'd10;
	localparam logic [3:0] S_SCM  = 4'd11;
	localparam logic [3:0] S_SCA  = 4'd12;
	localparam logic [3:0] S_CM   = 4'd13;
	localparam logic [3:0] S_CA   = 4'd14;
	localparam logic [3:0] S_WR   = 4'd15;

	localparam logic signed [69:0] SAT_MAX = 70'sd2147483647;
	localparam logic signed [69:0] SAT_MIN = -70'sd2147483648;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [69:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic [3:0]  state_q;
	logic        wr_b_q;
	logic        fin_q;
	logic [1:0]  op_q;
	logic [IDX_W-1:0] ia_q, ib_q;
	logic [REST_W-1:0] rest_q;
	logic [WEIGHT_W-1:0] wa_q, wb_q;
	logic signed [COORD_W-1:0] pa_q [3];
	logic signed [COORD_W-1:0] pb_q [3];
	logic signed [COORD_W:0]   d_q [3];
	logic [1:0]  k_q;
	logic        sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0]  sum_q;
	logic [SQ_W+1:0]  rad_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [NUMW-1:0]  dnum_q;
	logic [ROOT_W:0]  drem_q;
	logic [COORD_W:0] quo_q;
	logic        ovf_q, neg_q;
	logic signed [COORD_W-1:0] scale_q, sa_q, sb_q;
	logic        res_rd_q, res_deg_q, res_done_q;
	logic        out_valid_q;

	logic        accept, out_free;
	logic        a_ok, b_ok;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic [ROOT_W+2:0] rem_n;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W:0]   drem_n;
	logic signed [ROOT_W:0] diff;
	logic [ROOT_W-1:0] diff_mag;
	logic signed [PROD_W-1:0] tr_w, tr_f;
	logic signed [COORD_W-1:0] old_c, new_c;

	// busy, or a finished result still waiting for the output register
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (fin_q && !out_free);
	assign out_free = !out_valid_q || !out_stall;
	assign a_ok     = (32'(index_a) < PARTICLES);
	assign b_ok     = (32'(index_b) < PARTICLES);

	// store ports
	always_comb begin
		we    = 1'b0;
		waddr = AW'(ia_q);
		wdata = wr_b_q ? {pb_q[2], pb_q[1], pb_q[0]} : {pa_q[2], pa_q[1], pa_q[0]};
		if (state_q == S_IDLE) begin
			we    = accept && (opcode == OP_WRITE) && a_ok;
			waddr = AW'(index_a);
			wdata = {pos_z, pos_y, pos_x};
		end else if (state_q == S_WR) begin
			we    = 1'b1;
			waddr = wr_b_q ? AW'(ib_q) : AW'(ia_q);
		end
		raddr = (state_q == S_RDB) ? AW'(ib_q) : AW'(ia_q);
	end

	dcp_store #(.DEPTH(PARTICLES), .AW(AW)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQM: begin
				mul_a = MUL_W'(d_q[k_q]);
				mul_b = MUL_W'(d_q[k_q]);
			end
			S_SCM: begin
				mul_a = MUL_W'(scale_q);
				mul_b = $signed(MUL_W'(sel_q ? wb_q : wa_q));
			end
			S_CM: begin
				mul_a = MUL_W'(d_q[k_q]);
				mul_b = MUL_W'(sel_q ? sb_q : sa_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dcp_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// step logic of root, divide and truncation
	always_comb begin
		rem_n    = {rem_q[ROOT_W:0], rad_q[SQ_W+1:SQ_W]};
		trial    = {root_q, 2'b01};
		drem_n   = {drem_q[ROOT_W-1:0], dnum_q[NUMW-1]};
		diff     = $signed({4'b0, rest_q}) - $signed({1'b0, root_q});
		diff_mag = diff[ROOT_W] ? ROOT_W'(-diff) : diff[ROOT_W-1:0];
		tr_w     = (prod_s1 + (prod_s1[PROD_W-1] ? $signed(RND_W) : $signed(PROD_W'(0))))
		           >>> WEIGHT_FRAC;
		tr_f     = (prod_s1 + (prod_s1[PROD_W-1] ? $signed(RND_F) : $signed(PROD_W'(0))))
		           >>> FRACTION_BITS;
		old_c    = sel_q ? pb_q[k_q] : pa_q[k_q];
		new_c    = sel_q ? sat32(70'(old_c) - 70'(tr_f)) : sat32(70'(old_c) + 70'(tr_f));
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			wr_b_q  <= 1'b0;
			k_q     <= '0;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q <= 1'b1;
						if ((opcode == OP_READ && a_ok) ||
						    (opcode == OP_SOLVE && a_ok && b_ok)) begin
							state_q <= S_RDA;
							fin_q   <= 1'b0;
						end
					end else if (fin_q && out_free) begin
						fin_q <= 1'b0;
					end
				end
				S_RDA: state_q <= (op_q == OP_READ) ? S_DIFF : S_RDB;
				S_RDB: state_q <= S_DIFF;
				S_DIFF: begin
					k_q <= '0;
					if (op_q == OP_READ) begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
					end else begin
						state_q <= S_SQM;
					end
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? S_ZCHK : S_SQM;
				end
				S_ZCHK: begin
					cnt_q <= '0;
					if (sum_q == '0) begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= S_DVI;
					end
				end
				S_DVI: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUMW - 1)) begin
						state_q <= S_DVE;
					end
				end
				S_DVE: begin
					sel_q   <= 1'b0;
					state_q <= S_SCM;
				end
				S_SCM: state_q <= S_SCA;
				S_SCA: begin
					sel_q   <= !sel_q;
					k_q     <= '0;
					state_q <= sel_q ? S_CM : S_SCM;
				end
				S_CM: state_q <= S_CA;
				S_CA: begin
					sel_q <= !sel_q;
					if (sel_q) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							state_q <= S_WR;
							wr_b_q  <= 1'b0;
						end else begin
							state_q <= S_CM;
						end
					end else begin
						state_q <= S_CM;
					end
				end
				S_WR: begin
					wr_b_q <= 1'b1;
					if (wr_b_q) begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
						wr_b_q  <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode;
			ia_q       <= index_a;
			ib_q       <= index_b;
			rest_q     <= rest_length;
			wa_q       <= weight_a;
			wb_q       <= weight_b;
			res_rd_q   <= 1'b0;
			res_deg_q  <= 1'b0;
			res_done_q <= (opcode == OP_SOLVE) ? end_of_range : 1'b0;
		end
		unique case (state_q)
			S_RDB: begin
				for (int k = 0; k < 3; k++) begin
					pa_q[k] <= $signed(rdata_q[COORD_W*k +: COORD_W]);
				end
			end
			S_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					if (op_q == OP_READ) begin
						pa_q[k] <= $signed(rdata_q[COORD_W*k +: COORD_W]);
					end else begin
						pb_q[k] <= $signed(rdata_q[COORD_W*k +: COORD_W]);
						d_q[k]  <= (COORD_W+1)'(pa_q[k]) -
						           (COORD_W+1)'($signed(rdata_q[COORD_W*k +: COORD_W]));
					end
				end
				res_rd_q <= (op_q == OP_READ);
				sum_q    <= '0;
			end
			S_SQA: sum_q <= sum_q + SQ_W'(prod_s1);
			S_ZCHK: begin
				res_deg_q <= (sum_q == '0);
				rad_q     <= {2'b00, sum_q};
				rem_q     <= '0;
				root_q    <= '0;
			end
			S_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_n >= (ROOT_W+3)'(trial)) begin
					rem_q  <= rem_n - (ROOT_W+3)'(trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			S_DVI: begin
				neg_q  <= diff[ROOT_W];
				dnum_q <= {diff_mag, FRACTION_BITS'(0)};
				drem_q <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
			end
			S_DIV: begin
				dnum_q <= dnum_q << 1;
				ovf_q  <= ovf_q | quo_q[COORD_W];
				if (drem_n >= {1'b0, root_q}) begin
					drem_q <= drem_n - {1'b0, root_q};
					quo_q  <= {quo_q[COORD_W-1:0], 1'b1};
				end else begin
					drem_q <= drem_n;
					quo_q  <= {quo_q[COORD_W-1:0], 1'b0};
				end
			end
			S_DVE: begin
				if (!neg_q) begin
					if (ovf_q || quo_q[COORD_W:COORD_W-1] != 2'b00) begin
						scale_q <= 32'sh7FFFFFFF;
					end else begin
						scale_q <= $signed(quo_q[COORD_W-1:0]);
					end
				end else begin
					if (ovf_q || quo_q > 33'h080000000) begin
						scale_q <= 32'sh80000000;
					end else begin
						scale_q <= $signed(COORD_W'(-quo_q));
					end
				end
			end
			S_SCA: begin
				if (sel_q) begin
					sb_q <= sat32(70'(tr_w));
				end else begin
					sa_q <= sat32(70'(tr_w));
				end
			end
			S_CA: begin
				if (sel_q) begin
					pb_q[k_q] <= new_c;
				end else begin
					pa_q[k_q] <= new_c;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, loaded when the finished item finds it free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_IDLE && fin_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && fin_q && out_free) begin
			read_x     <= res_rd_q ? pa_q[0] : '0;
			read_y     <= res_rd_q ? pa_q[1] : '0;
			read_z     <= res_rd_q ? pa_q[2] : '0;
			degenerate <= res_deg_q;
			range_done <= res_done_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/dcp_store.sv =====
`default_nettype none
module dcp_store import dcp_pkg::*; #(
	parameter int DEPTH = PARTICLES_DEF,
	parameter int AW = $clog2(PARTICLES_DEF)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [ENTRY_W-1:0] wdata,
	input  wire logic [AW-1:0]      raddr,
	output logic      [ENTRY_W-1:0] rdata_q
);

	logic [ENTRY_W-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/dcp_mul.sv =====
`default_nettype none
module dcp_mul import dcp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed      [PROD_W-1:0] prod_s1
);

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule
`default_nettype wire
